[rtl/cia_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cia_pkg: shared types and constants
// Word layouts, register map, item kinds and timer control for the CIA block.
// ----------------------------------------------------------------------------
package cia_pkg;

	// longest tick honored in one item; longer ticks saturate
	localparam int MAX_TICKS = 255;
	localparam logic [7:0] TICK_SAT = 8'((MAX_TICKS > 255) ? 255 : MAX_TICKS);

	// item kinds
	localparam logic [1:0] MODE_READ  = 2'd0;
	localparam logic [1:0] MODE_WRITE = 2'd1;
	localparam logic [1:0] MODE_TICK  = 2'd2;
	localparam logic [1:0] MODE_FLAG  = 2'd3;

	// register map
	localparam logic [3:0] ADDR_PRA   = 4'd0;
	localparam logic [3:0] ADDR_PRB   = 4'd1;
	localparam logic [3:0] ADDR_DDRA  = 4'd2;
	localparam logic [3:0] ADDR_DDRB  = 4'd3;
	localparam logic [3:0] ADDR_TALO  = 4'd4;
	localparam logic [3:0] ADDR_TAHI  = 4'd5;
	localparam logic [3:0] ADDR_TBLO  = 4'd6;
	localparam logic [3:0] ADDR_TBHI  = 4'd7;
	localparam logic [3:0] ADDR_TOD10 = 4'd8;
	localparam logic [3:0] ADDR_TODS  = 4'd9;
	localparam logic [3:0] ADDR_TODM  = 4'd10;
	localparam logic [3:0] ADDR_TODH  = 4'd11;
	localparam logic [3:0] ADDR_SDR   = 4'd12;
	localparam logic [3:0] ADDR_ICR   = 4'd13;
	localparam logic [3:0] ADDR_CRA   = 4'd14;
	localparam logic [3:0] ADDR_CRB   = 4'd15;

	// control register bits
	localparam int CR_START   = 0;
	localparam int CR_ONESHOT = 3;
	localparam int CR_LOAD    = 4;
	localparam int CR_SPMODE  = 6;
	localparam int CR_TODIN   = 7;

	// interrupt sources
	localparam int INT_TA   = 0;
	localparam int INT_TB   = 1;
	localparam int INT_FLAG = 4;
	localparam int ICR_SET  = 7;

	// time-of-day byte masks
	localparam logic [7:0] TOD_MASK_TENTHS = 8'd15;
	localparam logic [7:0] TOD_MASK_MID    = 8'd127;
	localparam logic [7:0] TOD_MASK_HOURS  = 8'd255;

	typedef struct packed {
		logic [1:0] mode;
		logic [3:0] addr;
		logic [7:0] wdata;
		logic [7:0] tick_count;
		logic [7:0] pins_a;
		logic [7:0] pins_b;
	} req_t;

	typedef struct packed {
		logic [7:0] rdata;
		logic       irq;
		logic [7:0] port_a_data;
		logic [7:0] port_a_dir;
		logic       port_a_update;
		logic [7:0] port_b_data;
		logic [7:0] port_b_dir;
		logic       port_b_update;
		logic       serial_valid;
		logic [7:0] serial_data;
	} rsp_t;

	// strobes into one timer for the accepted word
	typedef struct packed {
		logic       tick;
		logic       wr_lo;
		logic       wr_hi;
		logic       wr_ctrl;
		logic [7:0] ticks;
		logic [7:0] wdata;
	} tmr_cmd_t;

	// timer state seen by the core
	typedef struct packed {
		logic [15:0] count;
		logic [7:0]  control;
		logic        expire;
	} tmr_stat_t;

endpackage
`default_nettype wire

[rtl/cia_timer.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cia_timer: 16-bit down timer
// Counter, reload latch and control register; counts down by the word's tick
// count on each tick word, reloads and flags on expiry, stops in one-shot mode.
// ----------------------------------------------------------------------------
module cia_timer
	import cia_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire tmr_cmd_t  cmd,
	output tmr_stat_t      stat
);

	logic [15:0] count_q;
	logic [15:0] reload_q;
	logic [7:0]  ctrl_q;
	logic [7:0]  ctrl_wr;
	logic        running;
	logic        expire;

	assign running = ctrl_q[CR_START];
	assign expire  = cmd.tick && running && (count_q <= {8'h00, cmd.ticks});

	assign stat.count   = count_q;
	assign stat.control = ctrl_q;
	assign stat.expire  = expire;

	// drop the load strobe from the stored control byte
	always_comb begin
		ctrl_wr          = cmd.wdata;
		ctrl_wr[CR_LOAD] = 1'b0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= '0;
			reload_q <= '0;
			ctrl_q   <= '0;
		end else begin
			if (cmd.wr_lo) begin
				reload_q[7:0] <= cmd.wdata;
			end
			if (cmd.wr_hi) begin
				reload_q[15:8] <= cmd.wdata;
				// stopped timer takes the new latch at once
				if (!running) begin
					count_q <= {cmd.wdata, reload_q[7:0]};
				end
			end
			if (cmd.wr_ctrl) begin
				ctrl_q <= ctrl_wr;
				if (cmd.wdata[CR_LOAD]) begin
					count_q <= reload_q;
				end
			end
			if (cmd.tick && running) begin
				if (expire) begin
					count_q <= reload_q;
					if (ctrl_q[CR_ONESHOT]) begin
						ctrl_q[CR_START] <= 1'b0;
					end
				end else begin
					count_q <= count_q - {8'h00, cmd.ticks};
				end
			end
		end
	end

endmodule
`default_nettype wire

[rtl/cia_core.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cia_core: register file and word decode
// Ports, direction, interrupt, serial and time-of-day registers plus both
// timers; updates state on an accepted word and forms its result.
// ----------------------------------------------------------------------------
module cia_core
	import cia_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  take,
	input  wire req_t  req,
	output rsp_t       rsp
);

	logic [7:0] pa_latch_q, pb_latch_q, dir_a_q, dir_b_q;
	logic [4:0] int_en_q, int_pend_q;
	logic [7:0] shift_q;
	logic [7:0] tod_q [4];

	logic       is_rd, is_wr, is_tick, is_flag;
	logic [7:0] ticks;
	tmr_cmd_t   cmd_a, cmd_b;
	tmr_stat_t  stat_a, stat_b;

	logic [7:0] pa_latch_nxt, pb_latch_nxt, dir_a_nxt, dir_b_nxt;
	logic [4:0] int_en_nxt, int_pend_nxt;
	logic       irq_cur;
	logic [7:0] rd_byte;
	logic [7:0] tod_mask;
	logic       tod_wr;
	logic       sdr_wr;

	assign is_rd   = take && (req.mode == MODE_READ);
	assign is_wr   = take && (req.mode == MODE_WRITE);
	assign is_tick = take && (req.mode == MODE_TICK);
	assign is_flag = take && (req.mode == MODE_FLAG);

	assign ticks = (req.tick_count > TICK_SAT) ? TICK_SAT : req.tick_count;

	always_comb begin
		cmd_a.tick    = is_tick;
		cmd_a.wr_lo   = is_wr && (req.addr == ADDR_TALO);
		cmd_a.wr_hi   = is_wr && (req.addr == ADDR_TAHI);
		cmd_a.wr_ctrl = is_wr && (req.addr == ADDR_CRA);
		cmd_a.ticks   = ticks;
		cmd_a.wdata   = req.wdata;
		cmd_b.tick    = is_tick;
		cmd_b.wr_lo   = is_wr && (req.addr == ADDR_TBLO);
		cmd_b.wr_hi   = is_wr && (req.addr == ADDR_TBHI);
		cmd_b.wr_ctrl = is_wr && (req.addr == ADDR_CRB);
		cmd_b.ticks   = ticks;
		cmd_b.wdata   = req.wdata;
	end

	cia_timer u_timer_a (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd_a),
		.stat   (stat_a)
	);

	cia_timer u_timer_b (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd_b),
		.stat   (stat_b)
	);

	assign irq_cur = |(int_en_q & int_pend_q);

	// next port state
	assign pa_latch_nxt = (is_wr && req.addr == ADDR_PRA) ? req.wdata : pa_latch_q;
	assign pb_latch_nxt = (is_wr && req.addr == ADDR_PRB) ? req.wdata : pb_latch_q;
	assign dir_a_nxt    = (is_wr && req.addr == ADDR_DDRA) ? req.wdata : dir_a_q;
	assign dir_b_nxt    = (is_wr && req.addr == ADDR_DDRB) ? req.wdata : dir_b_q;

	// next interrupt state
	always_comb begin
		int_en_nxt   = int_en_q;
		int_pend_nxt = int_pend_q;
		if (is_wr && req.addr == ADDR_ICR) begin
			if (req.wdata[ICR_SET]) begin
				int_en_nxt = int_en_q | req.wdata[4:0];
			end else begin
				int_en_nxt = int_en_q & ~req.wdata[4:0];
			end
		end
		if (is_rd && req.addr == ADDR_ICR) begin
			int_pend_nxt = '0;
		end
		if (is_tick) begin
			int_pend_nxt[INT_TA] = int_pend_q[INT_TA] | stat_a.expire;
			int_pend_nxt[INT_TB] = int_pend_q[INT_TB] | stat_b.expire;
		end
		if (is_flag) begin
			int_pend_nxt[INT_FLAG] = 1'b1;
		end
	end

	always_comb begin
		unique case (req.addr)
			ADDR_PRA:   rd_byte = (pa_latch_q & dir_a_q) | (req.pins_a & ~dir_a_q);
			ADDR_PRB:   rd_byte = (pb_latch_q & dir_b_q) | (req.pins_b & ~dir_b_q);
			ADDR_DDRA:  rd_byte = dir_a_q;
			ADDR_DDRB:  rd_byte = dir_b_q;
			ADDR_TALO:  rd_byte = stat_a.count[7:0];
			ADDR_TAHI:  rd_byte = stat_a.count[15:8];
			ADDR_TBLO:  rd_byte = stat_b.count[7:0];
			ADDR_TBHI:  rd_byte = stat_b.count[15:8];
			ADDR_TOD10: rd_byte = tod_q[0];
			ADDR_TODS:  rd_byte = tod_q[1];
			ADDR_TODM:  rd_byte = tod_q[2];
			ADDR_TODH:  rd_byte = tod_q[3];
			ADDR_SDR:   rd_byte = shift_q;
			ADDR_ICR:   rd_byte = {irq_cur, 2'b00, int_pend_q};
			ADDR_CRA:   rd_byte = stat_a.control;
			default:    rd_byte = stat_b.control;
		endcase
	end

	always_comb begin
		unique case (req.addr[1:0])
			2'd0:    tod_mask = TOD_MASK_TENTHS;
			2'd3:    tod_mask = TOD_MASK_HOURS;
			default: tod_mask = TOD_MASK_MID;
		endcase
	end

	// alarm writes are dropped
	assign tod_wr = is_wr && (req.addr[3:2] == ADDR_TOD10[3:2]) && !stat_b.control[CR_TODIN];
	assign sdr_wr = is_wr && (req.addr == ADDR_SDR);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pa_latch_q <= '0;
			pb_latch_q <= '0;
			dir_a_q    <= '0;
			dir_b_q    <= '0;
			int_en_q   <= '0;
			int_pend_q <= '0;
			shift_q    <= '0;
			for (int i = 0; i < 4; i++) begin
				tod_q[i] <= '0;
			end
		end else begin
			pa_latch_q <= pa_latch_nxt;
			pb_latch_q <= pb_latch_nxt;
			dir_a_q    <= dir_a_nxt;
			dir_b_q    <= dir_b_nxt;
			int_en_q   <= int_en_nxt;
			int_pend_q <= int_pend_nxt;
			if (sdr_wr) begin
				shift_q <= req.wdata;
			end
			if (tod_wr) begin
				tod_q[req.addr[1:0]] <= req.wdata & tod_mask;
			end
		end
	end

	always_comb begin
		rsp.rdata         = is_rd ? rd_byte : 8'h00;
		rsp.irq           = |(int_en_nxt & int_pend_nxt);
		rsp.port_a_data   = pa_latch_nxt;
		rsp.port_a_dir    = dir_a_nxt;
		rsp.port_a_update = (is_wr && req.addr == ADDR_PRA)
			|| (is_wr && req.addr == ADDR_DDRA && req.wdata != dir_a_q);
		rsp.port_b_data   = pb_latch_nxt;
		rsp.port_b_dir    = dir_b_nxt;
		rsp.port_b_update = (is_wr && req.addr == ADDR_PRB)
			|| (is_wr && req.addr == ADDR_DDRB && req.wdata != dir_b_q);
		rsp.serial_valid  = sdr_wr && stat_a.control[CR_SPMODE];
		rsp.serial_data   = (sdr_wr && stat_a.control[CR_SPMODE]) ? req.wdata : 8'h00;
	end

endmodule
`default_nettype wire

[rtl/cia_timer_port_interrupt_block.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cia_timer_port_interrupt_block: simplified 6526-style interface adapter
// Two I/O ports, two down timers, serial register, static time of day and a
// three-source interrupt controller, driven one bus/tick/flag word at a time.
// ----------------------------------------------------------------------------
//  channel | handshake             | payload
//  --------+-----------------------+---------------------------------------
//  req     | req_valid, req_ready  | req_t: mode, addr, wdata, tick, pins
//  rsp     | rsp_valid, rsp_ready  | rsp_t: rdata, irq, ports, serial
//
// Each word is decoded and applied to the registers at the edge it is
// taken; its result is captured into the response register at that same
// edge and offered from the next cycle on.
// One word per clock is sustained; the response register holds a word
// while rsp_ready is low and req_ready drops only then.
// Reset clears the state and the response valid flag; no clearing pass
// is needed.
// ----------------------------------------------------------------------------
module cia_timer_port_interrupt_block
	import cia_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic req_valid,
	output logic      req_ready,
	input  wire req_t req,
	output logic      rsp_valid,
	input  wire logic rsp_ready,
	output rsp_t      rsp
);

	logic rsp_valid_q;
	rsp_t rsp_q;
	rsp_t rsp_nxt;
	logic take;

	assign req_ready = !rsp_valid_q || rsp_ready;
	assign take      = req_valid && req_ready;

	cia_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.take   (take),
		.req    (req),
		.rsp    (rsp_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (req_ready) begin
			rsp_valid_q <= req_valid;
		end
	end

	// load a new word only when the slot is free or draining
	always_ff @(posedge clk) begin
		if (take) begin
			rsp_q <= rsp_nxt;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule
`default_nettype wire
